>>> rtl/core/life_generation_step_core_macros.svh
// Assertion macros for the life generation step core.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef LIFE_GENERATION_STEP_CORE_MACROS_SVH
`define LIFE_GENERATION_STEP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LGS_ASSERT_IMPLIES(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("lgs: same-cycle check failed");
`define LGS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("lgs: next-cycle check failed");
`else
`define LGS_ASSERT_IMPLIES(name, clk_s, rst_s, ante, cons)
`define LGS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons)
`endif
`endif

>>> rtl/core/lgs_pkg.sv
// Shared types and constants for the life generation step core.
// No dependencies; used by the interfaces and all core modules except lgs_row_mem.
`default_nettype none
package lgs_pkg;

  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 64;

  localparam int ACT_W      = 2;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 6;
  localparam int POP_W      = 14;
  localparam int GEN_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int GRID_W_W   = 8;
  localparam int GRID_H_W   = 7;

  localparam int MIN_DIM    = 3;
  localparam int WIDTH_RST  = 128;
  localparam int HEIGHT_RST = 64;

  // neighbor count rule B3/S23
  localparam int NBR_W      = 4;
  localparam logic [NBR_W-1:0] BIRTH_N   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_N = 4'd2;

  // population pipeline: segment count, group sum, accumulate
  localparam int POP_SEG_W  = 8;
  localparam int POP_GRP_N  = 8;
  localparam int POP_LAT    = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRAP   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_COUNT,
    S_STEP,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic valid;
  } pop_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/lgs_ifs.sv
// Valid/ready channel interfaces for commands and results.
// Depends on lgs_pkg for field widths.
`default_nettype none
interface lgs_cmd_if;
  import lgs_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             cell_value;

  modport source (output valid, action, col, row, cell_value, input ready);
  modport sink (input valid, action, col, row, cell_value, output ready);
endinterface

interface lgs_result_if;
  import lgs_pkg::*;
  logic             valid;
  logic             ready;
  logic             cell_state;
  logic [POP_W-1:0] population;
  logic [GEN_W-1:0] generation;
  logic             coord_error;

  modport source (output valid, cell_state, population, generation, coord_error, input ready);
  modport sink (input valid, cell_state, population, generation, coord_error, output ready);
endinterface
`default_nettype wire

>>> rtl/core/lgs_row_mem.sv
// Row-wide cell memory: one write port, one registered read port.
// No package dependencies.
`default_nettype none
module lgs_row_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/lgs_rule_unit.sv
// Row update unit: applies B3/S23 to one row from its three-row window.
// Depends on lgs_pkg for the rule constants.
`default_nettype none
module lgs_rule_unit #(
  parameter int COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  logic [COLS-1:0]           above,
  input  logic [COLS-1:0]           cur,
  input  logic [COLS-1:0]           below,
  input  logic [$clog2(COLS+1)-1:0] width,
  input  logic                      wrap,
  output logic [COLS-1:0]           new_row
);
  import lgs_pkg::*;

  localparam int WW = $clog2(COLS + 1);
  localparam int CW = $clog2(COLS);

  logic [CW-1:0] last_idx;
  logic          a_last, a_first, c_last, c_first, b_last, b_first;

  assign last_idx = CW'(width - WW'(1));
  assign a_last   = wrap & above[last_idx];
  assign c_last   = wrap & cur[last_idx];
  assign b_last   = wrap & below[last_idx];
  assign a_first  = wrap & above[0];
  assign c_first  = wrap & cur[0];
  assign b_first  = wrap & below[0];

  for (genvar c = 0; c < COLS; c++) begin : g_cell
    logic             al, ar, cl, cr, bl, br;
    logic [NBR_W-1:0] nbr;

    if (c == 0) begin : g_left_edge
      assign al = a_last;
      assign cl = c_last;
      assign bl = b_last;
    end else begin : g_left
      assign al = above[c-1];
      assign cl = cur[c-1];
      assign bl = below[c-1];
    end

    if (c < COLS - 1) begin : g_right
      assign ar = (c + 1 < width) ? above[c+1] : a_first;
      assign cr = (c + 1 < width) ? cur[c+1]   : c_first;
      assign br = (c + 1 < width) ? below[c+1] : b_first;
    end else begin : g_right_edge
      assign ar = a_first;
      assign cr = c_first;
      assign br = b_first;
    end

    assign nbr = NBR_W'(al) + NBR_W'(above[c]) + NBR_W'(ar)
               + NBR_W'(cl) + NBR_W'(cr)
               + NBR_W'(bl) + NBR_W'(below[c]) + NBR_W'(br);

    // cells beyond the active width keep their value
    assign new_row[c] = (c < width) ?
                        (cur[c] ? (nbr == SURVIVE_N || nbr == BIRTH_N) : (nbr == BIRTH_N)) :
                        cur[c];
  end

endmodule
`default_nettype wire

>>> rtl/core/lgs_pop_unit.sv
// Population counter: masks a row to the active width, counts it in a
// three-stage pipeline and accumulates. Depends on lgs_pkg.
`default_nettype none
module lgs_pop_unit #(
  parameter int COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lgs_pkg::pop_ctrl_t        ctrl,
  input  logic [COLS-1:0]           row_bits,
  input  logic [$clog2(COLS+1)-1:0] width,
  output logic [lgs_pkg::POP_W-1:0] total
);
  import lgs_pkg::*;

  localparam int NSEG   = (COLS + POP_SEG_W - 1) / POP_SEG_W;
  localparam int NGRP   = (NSEG + POP_GRP_N - 1) / POP_GRP_N;
  localparam int NSLOT  = NGRP * POP_GRP_N;
  localparam int PADW   = NSLOT * POP_SEG_W;
  localparam int SEGC_W = $clog2(POP_SEG_W + 1);
  localparam int GRPC_W = $clog2(POP_SEG_W * POP_GRP_N + 1);

  logic [COLS-1:0]   masked;
  logic [PADW-1:0]   padded;
  logic [SEGC_W-1:0] seg_comb [NSLOT];
  logic [SEGC_W-1:0] seg_q    [NSLOT];
  logic              seg_v;
  logic [GRPC_W-1:0] grp_comb [NGRP];
  logic [GRPC_W-1:0] grp_q    [NGRP];
  logic              grp_v;
  logic [POP_W-1:0]  total_next;

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      masked[c] = row_bits[c] & (c < width);
    end
  end

  assign padded = PADW'(masked);

  always_comb begin : seg_count
    logic [SEGC_W-1:0] acc;
    acc = '0;
    for (int s = 0; s < NSLOT; s++) begin
      acc = '0;
      for (int b = 0; b < POP_SEG_W; b++) begin
        acc = acc + SEGC_W'(padded[s*POP_SEG_W+b]);
      end
      seg_comb[s] = acc;
    end
  end

  always_comb begin : grp_sum
    logic [GRPC_W-1:0] acc;
    acc = '0;
    for (int g = 0; g < NGRP; g++) begin
      acc = '0;
      for (int k = 0; k < POP_GRP_N; k++) begin
        acc = acc + GRPC_W'(seg_q[g*POP_GRP_N+k]);
      end
      grp_comb[g] = acc;
    end
  end

  always_comb begin
    total_next = total;
    for (int g = 0; g < NGRP; g++) begin
      total_next = total_next + POP_W'(grp_q[g]);
    end
  end

  always_ff @(posedge clk) begin
    seg_q <= seg_comb;
    grp_q <= grp_comb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_v <= 1'b0;
      grp_v <= 1'b0;
      total <= '0;
    end else begin
      seg_v <= ctrl.valid;
      grp_v <= seg_v;
      if (ctrl.clr) begin
        total <= '0;
      end else if (grp_v) begin
        total <= total_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/life_generation_step_core.sv
// Life generation step core (B3/S23) with h active rows, one memory row per cycle.
// Each command is run by the sequencer and its result is loaded into the output
// register in S_DONE; a clear zeroes all MAX_ROWS rows; then the core returns to S_IDLE.
// Step pace is set by the single read port of the row memory and the shared row unit.
// Reset is synchronous; afterwards a sweep zeroes all MAX_ROWS rows, no commands.
`default_nettype none
`include "life_generation_step_core_macros.svh"
module life_generation_step_core #(
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_data,
  lgs_cmd_if.sink                        cmd,
  lgs_result_if.source                   result
);
  import lgs_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int WW = $clog2(MAX_COLS + 1);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int TW = $clog2(MAX_ROWS + POP_LAT + 8);

  // configuration
  logic                wrap_enable;
  logic [GRID_W_W-1:0] grid_width;
  logic [GRID_H_W-1:0] grid_height;
  logic [WW-1:0]       used_w;
  logic [HW-1:0]       used_h;

  // sequencer
  state_t        state, state_next;
  logic [TW-1:0] t;

  // captured command
  logic [ACT_W-1:0] act_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             val_q;
  logic             err_q;
  logic             cell_q;
  logic [GEN_W-1:0] gen;
  logic             cmd_err;

  // datapath
  logic              mem_we, mem_re;
  logic [RW-1:0]     mem_waddr, mem_raddr;
  logic [MAX_COLS-1:0] mem_wdata, mem_rdata;
  logic [MAX_COLS-1:0] mod_row, rule_row, pop_row;
  logic [MAX_COLS-1:0] win_above, win_cur, win_below, win_data, first_row;
  logic              win_shift;
  logic [MAX_COLS-1:0] new_row;
  logic [RW-1:0]     new_addr;
  logic              new_valid;
  logic [CW-1:0]     col_idx;
  logic              row_hit;
  pop_ctrl_t         pop_ctrl;
  logic [POP_W-1:0]  pop_total;

  // output register
  logic             cmd_ready, out_load, out_valid;
  logic             out_cell, out_err;
  logic [POP_W-1:0] out_pop;
  logic [GEN_W-1:0] out_gen;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_enable <= 1'b0;
      grid_width  <= GRID_W_W'(WIDTH_RST);
      grid_height <= GRID_H_W'(HEIGHT_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WRAP:   wrap_enable <= cfg_data[0];
        CFG_WIDTH:  grid_width  <= cfg_data[GRID_W_W-1:0];
        CFG_HEIGHT: grid_height <= cfg_data[GRID_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_width < MIN_DIM) begin
      used_w = WW'(MIN_DIM);
    end else if (grid_width > MAX_COLS) begin
      used_w = WW'(MAX_COLS);
    end else begin
      used_w = WW'(grid_width);
    end
    if (grid_height < MIN_DIM) begin
      used_h = HW'(MIN_DIM);
    end else if (grid_height > MAX_ROWS) begin
      used_h = HW'(MAX_ROWS);
    end else begin
      used_h = HW'(grid_height);
    end
  end

  assign cmd_err = (cmd.action == ACT_WRITE || cmd.action == ACT_READ) &&
                   (cmd.col >= used_w || cmd.row >= used_h);
  assign col_idx = CW'(col_q);
  assign row_hit = !err_q && ((t - TW'(1)) == TW'(row_q));

  always_comb begin
    mod_row = mem_rdata;
    if (row_hit && act_q == ACT_WRITE) begin
      mod_row[col_idx] = val_q;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (t == MAX_ROWS - 1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.valid) begin
          case (cmd.action)
            ACT_STEP:  state_next = S_STEP;
            ACT_CLEAR: state_next = S_CLEAR;
            default:   state_next = S_COUNT;
          endcase
        end
      end
      S_COUNT: begin
        if (t == used_h + POP_LAT - 1) state_next = S_DONE;
      end
      S_STEP: begin
        if (t == used_h + POP_LAT + 3) state_next = S_DONE;
      end
      S_CLEAR: begin
        if (t == MAX_ROWS - 1) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_ready = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = new_addr;
    mem_wdata = new_row;
    mem_re    = 1'b0;
    mem_raddr = RW'(t);
    pop_ctrl  = '0;
    pop_row   = new_row;
    win_shift = 1'b0;
    win_data  = mem_rdata;
    case (state)
      S_INIT, S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = RW'(t);
        mem_wdata = '0;
      end
      S_IDLE: begin
        cmd_ready    = 1'b1;
        pop_ctrl.clr = cmd.valid;
      end
      S_COUNT: begin
        mem_re    = (t < used_h);
        mem_raddr = RW'(t);
        if (t >= 1 && t <= used_h) begin
          pop_ctrl.valid = 1'b1;
          pop_row        = mod_row;
          mem_we         = row_hit && act_q == ACT_WRITE;
          mem_waddr      = RW'(t - TW'(1));
          mem_wdata      = mod_row;
        end
      end
      S_STEP: begin
        // reads: last row first (wrap above of row 0), then rows 0..h-1
        mem_re    = (t <= used_h);
        mem_raddr = (t == '0) ? RW'(used_h - HW'(1)) : RW'(t - TW'(1));
        win_shift = (t >= 1 && t <= used_h + 2);
        if (t == TW'(1)) begin
          win_data = wrap_enable ? mem_rdata : '0;
        end else if (t <= used_h + 1) begin
          win_data = mem_rdata;
        end else begin
          win_data = wrap_enable ? first_row : '0;
        end
        mem_we         = new_valid;
        pop_ctrl.valid = new_valid;
      end
      S_DONE: begin
        out_load = !out_valid || result.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      t     <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        t <= '0;
      end else begin
        t <= t + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen <= '0;
    end else if (cmd.valid && cmd_ready) begin
      if (cmd.action == ACT_STEP) begin
        gen <= gen + GEN_W'(1);
      end else if (cmd.action == ACT_CLEAR) begin
        gen <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd_ready) begin
      act_q  <= cmd.action;
      col_q  <= cmd.col;
      row_q  <= cmd.row;
      val_q  <= cmd.cell_value;
      err_q  <= cmd_err;
      cell_q <= 1'b0;
    end else if (state == S_COUNT && t >= 1 && t <= used_h && row_hit &&
                 act_q == ACT_READ) begin
      cell_q <= mem_rdata[col_idx];
    end
  end

  // three-row window for the step
  always_ff @(posedge clk) begin
    if (win_shift) begin
      win_above <= win_cur;
      win_cur   <= win_below;
      win_below <= win_data;
    end
    if (state == S_STEP && t == TW'(2)) begin
      first_row <= mem_rdata;
    end
    new_row  <= rule_row;
    new_addr <= RW'(t - TW'(4));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      new_valid <= 1'b0;
    end else begin
      new_valid <= (state == S_STEP) && (t >= 4) && (t <= used_h + 3);
    end
  end

  lgs_row_mem #(
    .DEPTH (MAX_ROWS),
    .WIDTH (MAX_COLS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lgs_rule_unit #(
    .COLS (MAX_COLS)
  ) u_rule (
    .above   (win_above),
    .cur     (win_cur),
    .below   (win_below),
    .width   (used_w),
    .wrap    (wrap_enable),
    .new_row (rule_row)
  );

  lgs_pop_unit #(
    .COLS (MAX_COLS)
  ) u_pop (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (pop_ctrl),
    .row_bits (pop_row),
    .width    (used_w),
    .total    (pop_total)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cell <= cell_q;
      out_pop  <= pop_total;
      out_gen  <= gen;
      out_err  <= err_q;
    end
  end

  assign cmd.ready          = cmd_ready;
  assign result.valid       = out_valid;
  assign result.cell_state  = out_cell;
  assign result.population  = out_pop;
  assign result.generation  = out_gen;
  assign result.coord_error = out_err;

  `LGS_ASSERT_IMPLIES(a_step_row_in_grid, clk, rst, new_valid, new_addr < used_h)
  `LGS_ASSERT_NEXT(a_clear_zero_gen, clk, rst, cmd.valid && cmd_ready && cmd.action == ACT_CLEAR, gen == '0)
  `LGS_ASSERT_IMPLIES(a_sweep_no_count, clk, rst, state == S_INIT || state == S_CLEAR, !pop_ctrl.valid)
  `LGS_ASSERT_IMPLIES(a_idle_no_write, clk, rst, cmd_ready, !mem_we && !new_valid)

endmodule
`default_nettype wire
